// ===== rtl/core/rcp_pkg.sv =====
// Shared types and constants for the rectangle canvas painter.
// No dependencies; imported by every module of the block.
package rcp_pkg;

    // Canvas geometry and coordinate format
    localparam int MAX_SIDE   = 512;
    localparam int SIDE_BITS  = $clog2(MAX_SIDE);
    localparam int DIM_BITS   = SIDE_BITS + 1;
    localparam int ADDR_BITS  = 2 * SIDE_BITS;
    localparam int FRAC_BITS  = 8;
    localparam int COORD_W    = 24;
    // wide enough for right/bottom edge minus a pixel position
    localparam int CALC_W     = COORD_W + 3;
    localparam int CHAR_W     = 8;
    localparam int CFG_DATA_W = 10;

    // Operation codes
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_DRAW  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Result status codes
    localparam logic [1:0] STS_DONE    = 2'd0;
    localparam logic [1:0] STS_REJECT  = 2'd1;
    localparam logic [1:0] STS_IGNORED = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BGCHAR = 2'd2;

    // Shape letters
    localparam logic [7:0] LETTER_OUTLINE = 8'h72;  // 'r'
    localparam logic [7:0] LETTER_FILLED  = 8'h52;  // 'R'

    // Controller to datapath commands
    typedef struct packed {
        logic accept;      // capture the incoming item
        logic sweep_step;  // visit one pixel, advance counters
        logic rd_en;       // read one canvas byte
        logic load_out;    // move the result into the output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic start_sweep;  // incoming item needs a full canvas pass
        logic start_read;   // incoming item reads a pixel
        logic sweep_last;   // current pixel is the last one of the pass
    } t_dp_sts;

endpackage

// ===== rtl/core/rcp_ctrl.sv =====
// Controller state machine for the rectangle canvas painter.
// Depends on rcp_pkg; drives the datapath through t_dp_cmd.
module rcp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    output logic             o_valid,
    input  logic             i_stall,
    input  rcp_pkg::t_dp_sts i_sts,
    output rcp_pkg::t_dp_cmd o_cmd
);
    import rcp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SWEEP  = 4'b0010,
        S_READ   = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;
    assign out_free = !r_out_valid || !i_stall;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.start_sweep) begin
                        n_state = S_SWEEP;
                    end else if (i_sts.start_read) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_FINISH;
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_FINISH;
            end
            S_FINISH: begin
                // wait for the output register to free up
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/core/rcp_datapath.sv =====
// Datapath for the rectangle canvas painter: config registers, canvas
// memory, pixel counters, rectangle classifier, result register. Uses rcp_pkg.
module rcp_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_index,
    input  logic [rcp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // incoming item
    input  logic [1:0]                     i_operation,
    input  logic [rcp_pkg::CHAR_W-1:0]     i_shape_letter,
    input  logic signed [rcp_pkg::COORD_W-1:0] i_left_edge,
    input  logic signed [rcp_pkg::COORD_W-1:0] i_top_edge,
    input  logic signed [rcp_pkg::COORD_W-1:0] i_rect_width,
    input  logic signed [rcp_pkg::COORD_W-1:0] i_rect_height,
    input  logic [rcp_pkg::CHAR_W-1:0]     i_paint_char,
    input  logic [rcp_pkg::SIDE_BITS-1:0]  i_read_col,
    input  logic [rcp_pkg::SIDE_BITS-1:0]  i_read_row,
    // control
    input  rcp_pkg::t_dp_cmd               i_cmd,
    output rcp_pkg::t_dp_sts               o_sts,
    // result
    output logic [1:0]                     o_status,
    output logic [rcp_pkg::CHAR_W-1:0]     o_pixel_value
);
    import rcp_pkg::*;

    localparam logic signed [CALC_W-1:0] ONE = CALC_W'(1) <<< FRAC_BITS;

    // Configuration registers
    logic [DIM_BITS-1:0] r_cfg_width, r_cfg_height;
    logic [CHAR_W-1:0]   r_bg_char;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= DIM_BITS'(1);
            r_cfg_height <= DIM_BITS'(1);
            r_bg_char    <= CHAR_W'(32);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WIDTH:  r_cfg_width  <= i_cfg_data[DIM_BITS-1:0];
                REG_HEIGHT: r_cfg_height <= i_cfg_data[DIM_BITS-1:0];
                REG_BGCHAR: r_bg_char    <= i_cfg_data[CHAR_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp a side register into 1..MAX_SIDE
    function automatic logic [DIM_BITS-1:0] used_side(input logic [DIM_BITS-1:0] v);
        logic [DIM_BITS-1:0] res;
        res = v;
        if (v == '0) begin
            res = DIM_BITS'(1);
        end else if (v > DIM_BITS'(MAX_SIDE)) begin
            res = DIM_BITS'(MAX_SIDE);
        end
        return res;
    endfunction

    logic [DIM_BITS-1:0] used_w, used_h;
    assign used_w = used_side(r_cfg_width);
    assign used_h = used_side(r_cfg_height);

    // Decode of the incoming item
    logic r_err;
    logic shape_ok, draw_ok, is_filled_in;
    assign shape_ok = (i_shape_letter == LETTER_OUTLINE) ||
                      (i_shape_letter == LETTER_FILLED);
    assign draw_ok  = (i_rect_width > 0) && (i_rect_height > 0) && shape_ok;
    assign is_filled_in = (i_shape_letter == LETTER_FILLED);

    assign o_sts.start_sweep = (i_operation == OP_CLEAR) ||
                               ((i_operation == OP_DRAW) && !r_err && draw_ok);
    assign o_sts.start_read  = (i_operation == OP_READ);

    logic [1:0] item_status;
    always_comb begin
        item_status = STS_DONE;
        if (i_operation == OP_DRAW) begin
            if (r_err) begin
                item_status = STS_IGNORED;
            end else if (!draw_ok) begin
                item_status = STS_REJECT;
            end
        end
    end

    // Error latch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err <= 1'b0;
        end else if (i_cmd.accept) begin
            if (i_operation == OP_CLEAR) begin
                r_err <= 1'b0;
            end else if ((i_operation == OP_DRAW) && !draw_ok) begin
                r_err <= 1'b1;
            end
        end
    end

    // Captured item
    logic                     r_is_clear, r_filled, r_read_in;
    logic [CHAR_W-1:0]        r_wchar;
    logic signed [CALC_W-1:0] r_l, r_t, r_r, r_b;
    logic [DIM_BITS-1:0]      r_w, r_h;
    logic [SIDE_BITS-1:0]     r_rcol, r_rrow;
    logic [1:0]               r_item_status;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_is_clear    <= (i_operation == OP_CLEAR);
            r_filled      <= is_filled_in;
            r_wchar       <= (i_operation == OP_CLEAR) ? r_bg_char : i_paint_char;
            r_l           <= CALC_W'(i_left_edge);
            r_t           <= CALC_W'(i_top_edge);
            r_r           <= CALC_W'(i_left_edge) + CALC_W'(i_rect_width);
            r_b           <= CALC_W'(i_top_edge) + CALC_W'(i_rect_height);
            r_w           <= used_w;
            r_h           <= used_h;
            r_rcol        <= i_read_col;
            r_rrow        <= i_read_row;
            r_read_in     <= (i_operation == OP_READ) &&
                             (DIM_BITS'(i_read_col) < used_w) &&
                             (DIM_BITS'(i_read_row) < used_h);
            r_item_status <= item_status;
        end
    end

    // Pixel counters, row-major over the used area
    logic [SIDE_BITS-1:0] r_x, r_y;
    logic                 x_last, y_last;
    assign x_last = (DIM_BITS'(r_x) == r_w - DIM_BITS'(1));
    assign y_last = (DIM_BITS'(r_y) == r_h - DIM_BITS'(1));
    assign o_sts.sweep_last = x_last && y_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_y <= '0;
        end else if (i_cmd.accept) begin
            r_x <= '0;
            r_y <= '0;
        end else if (i_cmd.sweep_step) begin
            if (x_last) begin
                r_x <= '0;
                r_y <= r_y + SIDE_BITS'(1);
            end else begin
                r_x <= r_x + SIDE_BITS'(1);
            end
        end
    end

    // Classifier: pixel positions in the same fixed-point units
    logic signed [CALC_W-1:0] px, py, d_l, d_r, d_t, d_b;
    logic                     in_rect, border, paint;
    assign px  = $signed(CALC_W'({r_x, {FRAC_BITS{1'b0}}}));
    assign py  = $signed(CALC_W'({r_y, {FRAC_BITS{1'b0}}}));
    assign d_l = px - r_l;
    assign d_r = r_r - px;
    assign d_t = py - r_t;
    assign d_b = r_b - py;
    assign in_rect = (d_l >= 0) && (d_r >= 0) && (d_t >= 0) && (d_b >= 0);
    assign border  = (d_l < ONE) || (d_r < ONE) || (d_t < ONE) || (d_b < ONE);
    assign paint   = r_is_clear || (in_rect && (border || r_filled));

    // Canvas memory
    logic [CHAR_W-1:0]    mem [MAX_SIDE*MAX_SIDE];
    logic [CHAR_W-1:0]    r_rd_data;
    logic [ADDR_BITS-1:0] waddr, raddr;
    assign waddr = {r_y, r_x};
    assign raddr = {r_rrow, r_rcol};

    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep_step && paint) begin
            mem[waddr] <= r_wchar;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[raddr];
        end
    end

    // Result register
    logic [1:0]        r_out_status;
    logic [CHAR_W-1:0] r_out_pixel;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= r_item_status;
            r_out_pixel  <= r_read_in ? r_rd_data : '0;
        end
    end

    assign o_status      = r_out_status;
    assign o_pixel_value = r_out_pixel;

endmodule

// ===== rtl/core/rectangle_canvas_painter.sv =====
// Rectangle canvas painter: clears, draws rectangles into and reads a byte canvas.
// Top level; instantiates rcp_ctrl and rcp_datapath, uses rcp_pkg.
//
// Usage:
//   Input channel (i_valid / o_stall): one item per handshake; operation 0
//   clears the used area to the background character, 1 draws a rectangle,
//   2 reads one pixel. Output channel (o_valid / i_stall): one result per item
//   with a status code and, for reads, the pixel value.
//   Config channel (i_cfg_valid / o_cfg_ready): always ready; index selects
//   canvas width, canvas height or background character. Write only when idle.
//   From accept to result: clear or accepted draw sweep the used area one
//   pixel per cycle through the single canvas write port, a read does one
//   canvas read, other items go straight to the result-load state.
//   One item is in flight at a time; o_stall is high until its result has
//   been loaded into the output register, so the next item can be accepted
//   while that result still waits for the receiver.
//   If the receiver stalls, the result holds and a finished item waits in the
//   controller until the output register frees.
//   Reset clears control state and the error latch and sets width and height
//   to 1 and the background to 32. Canvas contents are undefined until a
//   clear writes them; there is no clearing pass.
module rectangle_canvas_painter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input item channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [1:0]                         i_operation,
    input  logic [rcp_pkg::CHAR_W-1:0]         i_shape_letter,
    input  logic signed [rcp_pkg::COORD_W-1:0] i_left_edge,
    input  logic signed [rcp_pkg::COORD_W-1:0] i_top_edge,
    input  logic signed [rcp_pkg::COORD_W-1:0] i_rect_width,
    input  logic signed [rcp_pkg::COORD_W-1:0] i_rect_height,
    input  logic [rcp_pkg::CHAR_W-1:0]         i_paint_char,
    input  logic [rcp_pkg::SIDE_BITS-1:0]      i_read_col,
    input  logic [rcp_pkg::SIDE_BITS-1:0]      i_read_row,
    // result channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [1:0]                         o_status,
    output logic [rcp_pkg::CHAR_W-1:0]         o_pixel_value,
    // configuration channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [1:0]                         i_cfg_index,
    input  logic [rcp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import rcp_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    rcp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    rcp_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_operation    (i_operation),
        .i_shape_letter (i_shape_letter),
        .i_left_edge    (i_left_edge),
        .i_top_edge     (i_top_edge),
        .i_rect_width   (i_rect_width),
        .i_rect_height  (i_rect_height),
        .i_paint_char   (i_paint_char),
        .i_read_col     (i_read_col),
        .i_read_row     (i_read_row),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_status       (o_status),
        .o_pixel_value  (o_pixel_value)
    );

endmodule

// ===== rtl/core/rcp_checker.sv =====
// Port-level checks for the rectangle canvas painter, bound to the top level.
// Uses rcp_pkg for status codes and widths.
module rcp_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_stall,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic [1:0]                 o_status,
    input logic [rcp_pkg::CHAR_W-1:0] o_pixel_value
);
    import rcp_pkg::*;

    // the block stalls its input in the cycle after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken again right after an accept");

    // stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_status) && $stable(o_pixel_value)))
        else $error("stalled result changed");

    // only defined status codes appear
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == STS_DONE || o_status == STS_REJECT ||
                     o_status == STS_IGNORED))
        else $error("undefined status code");

    // rejected or ignored draws carry no pixel
    a_pixel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != STS_DONE) |-> (o_pixel_value == '0))
        else $error("pixel value on a non-done result");

    // reset empties the output
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind rectangle_canvas_painter rcp_checker u_rcp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_status      (o_status),
    .o_pixel_value (o_pixel_value)
);
